// ===== sv/pbu_pkg.sv =====
package pbu_pkg;

    // Default sizes
    localparam int NUM_STATES_DEF       = 16;
    localparam int NUM_ACTIONS_DEF      = 8;
    localparam int NUM_OBSERVATIONS_DEF = 16;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 4;
    localparam int OBS_W  = 4;
    localparam int PROB_W = 16;

    // Q1.15 arithmetic
    localparam int FRAC   = 15;
    localparam int PART_W = 2 * PROB_W - FRAC;       // (b*T)>>15
    localparam int TERM_W = PART_W + PROB_W - FRAC;  // (part*O)>>15
    localparam int Q_W    = 16;                      // normalized value, up to 32768

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // Command codes (s_tuser)
    localparam logic [CMD_W-1:0] CMD_WR_T   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_O   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WR_B   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

    // Controls shared by every cell of the ring
    typedef struct packed {
        logic            b_shift;
        logic            b_wr;
        logic [ST_W-1:0] b_wr_idx;
        logic            ob_shift;
        logic            acc_shift;
        logic            acc_clr;
    } cell_ctrl_t;

endpackage

// ===== sv/pbu_ram.sv =====
module pbu_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pbu_cell.sv =====
module pbu_cell #(
    parameter int IDX   = 0,
    parameter int ACC_W = 22
) (
    input  logic                      aclk,
    input  pbu_pkg::cell_ctrl_t       ctrl,
    input  logic [pbu_pkg::PROB_W-1:0] wr_data,
    input  logic [pbu_pkg::PROB_W-1:0] b_in,
    input  logic [pbu_pkg::PROB_W-1:0] ob_in,
    input  logic [ACC_W-1:0]          acc_in,
    output logic [pbu_pkg::PROB_W-1:0] b_out,
    output logic [pbu_pkg::PROB_W-1:0] ob_out,
    output logic [ACC_W-1:0]          acc_out
);
    import pbu_pkg::*;

    logic [PROB_W-1:0] b_reg;
    logic [PROB_W-1:0] ob_reg;
    logic [ACC_W-1:0]  acc_reg;

    // belief: direct write when the ring is at rest, else shift toward head
    always_ff @(posedge aclk) begin
        if (ctrl.b_wr && (int'(ctrl.b_wr_idx) == IDX)) begin
            b_reg <= wr_data;
        end else if (ctrl.b_shift) begin
            b_reg <= b_in;
        end
        if (ctrl.ob_shift) begin
            ob_reg <= ob_in;
        end
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_shift) begin
            acc_reg <= acc_in;
        end
    end

    assign b_out   = b_reg;
    assign ob_out  = ob_reg;
    assign acc_out = acc_reg;

endmodule

// ===== sv/pbu_div.sv =====
module pbu_div #(
    parameter int SUM_W = 26
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [SUM_W-1:0]         dividend,
    input  logic [SUM_W-1:0]         divisor,
    output logic                     busy,
    output logic [pbu_pkg::Q_W-1:0]  quotient
);
    import pbu_pkg::*;

    localparam int R_W        = SUM_W + 1;
    localparam int DIV_CYCLES = Q_W / 2;
    localparam int CNT_W      = $clog2(DIV_CYCLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

    logic [R_W-1:0]   r_reg, r_next;
    logic [SUM_W-1:0] d_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [R_W-1:0] d_ext, in2, rem1, rem2;
    logic           bit1, bit2;

    // two restoring steps per cycle; the remainder stays below the divisor
    always_comb begin
        d_ext  = {1'b0, d_reg};
        bit1   = (r_reg >= d_ext);
        rem1   = bit1 ? (r_reg - d_ext) : r_reg;
        in2    = {rem1[SUM_W-1:0], 1'b0};
        bit2   = (in2 >= d_ext);
        rem2   = bit2 ? (in2 - d_ext) : in2;
        r_next = {rem2[SUM_W-1:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg <= {1'b0, dividend};
            d_reg <= divisor;
        end else if (busy_reg) begin
            r_reg <= r_next;
            q_reg <= {q_reg[Q_W-3:0], bit1, bit2};
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ===== sv/pomdp_belief_update_top.sv =====
// Discrete POMDP / HMM forward belief update, unsigned Q1.15.
//
// Input stream (s_*): s_tuser carries the command (write transition entry,
// write observation entry, write belief entry, update). Writes are absorbed
// and give no output. An update with an in-range action and
// observation produces NUM_STATES output transactions on m_*, index order,
// m_tlast on the final index, m_tuser set on all of them when the
// unnormalized sum was zero (belief then re-emitted unchanged).
//
// An update runs an observation preload, then one multiply-accumulate per
// cycle through a pipeline (table read, belief-transition product,
// observation product) into the accumulator ring, a drain, and then per
// state a load, the radix-4 divider, a wait for it to finish and the emit
// (the divider is skipped when the unnormalized sum is zero).
// s_tready is high only between updates; the next item is taken once the last
// result sits in the output register.
// Reset (aresetn low, synchronous) returns the control to idle and drops
// m_tvalid; the tables and the belief are undefined until written. When the
// receiver stalls, the output register holds its transaction and the
// normalization pass waits.
module pomdp_belief_update_top #(
    parameter int NUM_STATES       = pbu_pkg::NUM_STATES_DEF,
    parameter int NUM_ACTIONS      = pbu_pkg::NUM_ACTIONS_DEF,
    parameter int NUM_OBSERVATIONS = pbu_pkg::NUM_OBSERVATIONS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] action, [6:3] from_state, [10:7] to_state, [14:11] observation,
    // [30:15] probability
    input  logic [pbu_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [pbu_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] state_index, [19:4] belief_value
    output logic [pbu_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] zero_sum
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import pbu_pkg::*;

    localparam int IDX_W = $clog2(NUM_STATES);
    localparam int ACC_W = TERM_W + IDX_W;
    localparam int SUM_W = TERM_W + 2 * IDX_W;
    localparam int T_DEPTH = NUM_ACTIONS * NUM_STATES * NUM_STATES;
    localparam int O_DEPTH = NUM_ACTIONS * NUM_STATES * NUM_OBSERVATIONS;
    localparam int T_AW = $clog2(T_DEPTH);
    localparam int O_AW = $clog2(O_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STATES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OPRE  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DLOAD = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // input fields
    logic [ACT_W-1:0]  in_act;
    logic [ST_W-1:0]   in_src, in_dst;
    logic [OBS_W-1:0]  in_obs;
    logic [PROB_W-1:0] in_prob;
    logic              s_acc, act_ok, src_ok, dst_ok, obs_ok, upd_start;

    assign in_act  = s_tdata[2:0];
    assign in_src  = s_tdata[6:3];
    assign in_dst  = s_tdata[10:7];
    assign in_obs  = s_tdata[14:11];
    assign in_prob = s_tdata[30:15];

    logic [2:0]       state_reg;
    logic [IDX_W-1:0] i_reg, j_reg, e_reg;
    logic [ACT_W-1:0] act_reg;
    logic [OBS_W-1:0] obs_reg;
    logic             zero_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign act_ok    = int'(in_act) < NUM_ACTIONS;
    assign src_ok    = int'(in_src) < NUM_STATES;
    assign dst_ok    = int'(in_dst) < NUM_STATES;
    assign obs_ok    = int'(in_obs) < NUM_OBSERVATIONS;
    assign upd_start = s_acc && (s_tuser == CMD_UPDATE) && act_ok && obs_ok;

    // table memories
    logic              t_we, o_we;
    logic [T_AW-1:0]   t_waddr, t_raddr;
    logic [O_AW-1:0]   o_waddr, o_raddr;
    logic [PROB_W-1:0] t_rdata, o_rdata;

    assign t_we    = s_acc && (s_tuser == CMD_WR_T) && act_ok && src_ok && dst_ok;
    assign o_we    = s_acc && (s_tuser == CMD_WR_O) && act_ok && dst_ok && obs_ok;
    assign t_waddr = T_AW'((int'(in_act) * NUM_STATES + int'(in_src)) * NUM_STATES
                           + int'(in_dst));
    assign o_waddr = O_AW'((int'(in_act) * NUM_STATES + int'(in_dst)) * NUM_OBSERVATIONS
                           + int'(in_obs));
    assign t_raddr = T_AW'((int'(act_reg) * NUM_STATES + int'(j_reg)) * NUM_STATES
                           + int'(i_reg));
    assign o_raddr = O_AW'((int'(act_reg) * NUM_STATES + int'(i_reg)) * NUM_OBSERVATIONS
                           + int'(obs_reg));

    pbu_ram #(.W(PROB_W), .DEPTH(T_DEPTH)) u_t_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (in_prob),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    pbu_ram #(.W(PROB_W), .DEPTH(O_DEPTH)) u_o_ram (
        .aclk  (aclk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (in_prob),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    // MAC pipeline
    logic              v0_reg, v1_reg, v2_reg, o_rd_v_reg;
    logic [PROB_W-1:0] bq_reg;
    logic [PART_W-1:0] p1_reg;
    logic [TERM_W-1:0] p2_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [2*PROB_W-1:0]      prod1;
    logic [PART_W+PROB_W-1:0] prod2;

    // cell ring
    cell_ctrl_t        cell_ctrl;
    logic [PROB_W-1:0] b_arr  [NUM_STATES];
    logic [PROB_W-1:0] ob_arr [NUM_STATES];
    logic [ACC_W-1:0]  acc_arr[NUM_STATES];
    logic [PROB_W-1:0] b_tail, ob_tail;
    logic [ACC_W-1:0]  acc_tail;

    // divider and output
    logic              div_start, div_busy;
    logic [Q_W-1:0]    div_q;
    logic              out_load;
    logic [PROB_W-1:0] out_value;
    logic              m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [ST_W-1:0]   out_idx_reg;
    logic [PROB_W-1:0] out_val_reg;

    assign prod1 = bq_reg * t_rdata;
    assign prod2 = p1_reg * ob_arr[0];

    assign out_load  = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
    assign out_value = zero_reg ? b_arr[0] : div_q[PROB_W-1:0];
    assign div_start = (state_reg == S_DLOAD);

    always_comb begin
        cell_ctrl.b_shift   = ((state_reg == S_MAC) && (i_reg == LAST_IDX)) || out_load;
        cell_ctrl.b_wr      = s_acc && (s_tuser == CMD_WR_B) && src_ok;
        cell_ctrl.b_wr_idx  = in_src;
        cell_ctrl.ob_shift  = o_rd_v_reg || v1_reg;
        cell_ctrl.acc_shift = v2_reg || div_start;
        cell_ctrl.acc_clr   = upd_start;
        b_tail   = out_load ? out_value : b_arr[0];
        ob_tail  = o_rd_v_reg ? o_rdata : ob_arr[0];
        acc_tail = v2_reg ? (acc_arr[0] + {{(ACC_W-TERM_W){1'b0}}, p2_reg}) : acc_arr[0];
    end

    for (genvar k = 0; k < NUM_STATES; k++) begin : g_cell
        logic [PROB_W-1:0] b_in, ob_in;
        logic [ACC_W-1:0]  acc_in;
        if (k == NUM_STATES - 1) begin : g_tail
            assign b_in   = b_tail;
            assign ob_in  = ob_tail;
            assign acc_in = acc_tail;
        end else begin : g_mid
            assign b_in   = b_arr[k+1];
            assign ob_in  = ob_arr[k+1];
            assign acc_in = acc_arr[k+1];
        end
        pbu_cell #(.IDX(k), .ACC_W(ACC_W)) u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctrl),
            .wr_data (in_prob),
            .b_in    (b_in),
            .ob_in   (ob_in),
            .acc_in  (acc_in),
            .b_out   (b_arr[k]),
            .ob_out  (ob_arr[k]),
            .acc_out (acc_arr[k])
        );
    end

    pbu_div #(.SUM_W(SUM_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({{(SUM_W-ACC_W){1'b0}}, acc_arr[0]}),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            e_reg      <= '0;
            zero_reg   <= 1'b0;
            v0_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            o_rd_v_reg <= 1'b0;
        end else begin
            v0_reg     <= (state_reg == S_MAC);
            v1_reg     <= v0_reg;
            v2_reg     <= v1_reg;
            o_rd_v_reg <= (state_reg == S_OPRE);
            unique case (state_reg)
                S_IDLE: begin
                    if (upd_start) begin
                        state_reg <= S_OPRE;
                        i_reg     <= '0;
                    end
                end
                S_OPRE: begin
                    if (i_reg == LAST_IDX) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_MAC;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_MAC: begin
                    if (i_reg == LAST_IDX) begin
                        i_reg <= '0;
                        j_reg <= j_reg + 1'b1;
                        if (j_reg == LAST_IDX) begin
                            state_reg <= S_DRAIN;
                        end
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!v0_reg && !v1_reg && !v2_reg) begin
                        e_reg     <= '0;
                        zero_reg  <= (sum_reg == '0);
                        state_reg <= (sum_reg == '0) ? S_EMIT : S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (!div_busy) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        e_reg <= e_reg + 1'b1;
                        if (e_reg == LAST_IDX) begin
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= zero_reg ? S_EMIT : S_DLOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (upd_start) begin
            act_reg <= in_act;
            obs_reg <= in_obs;
        end
        bq_reg <= b_arr[0];
        p1_reg <= prod1[2*PROB_W-1:FRAC];
        p2_reg <= prod2[PART_W+PROB_W-1:FRAC];
        if (upd_start) begin
            sum_reg <= '0;
        end else if (v2_reg) begin
            sum_reg <= sum_reg + {{(SUM_W-TERM_W){1'b0}}, p2_reg};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_idx_reg <= ST_W'(e_reg);
            out_val_reg <= out_value;
            m_tuser_reg <= zero_reg;
            m_tlast_reg <= (e_reg == LAST_IDX);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-ST_W-PROB_W){1'b0}}, out_val_reg, out_idx_reg};
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_idle_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !(v0_reg || v1_reg || v2_reg))
        else $error("MAC pipeline busy while idle");

    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    a_dload_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DLOAD) |=> div_busy)
        else $error("divider did not start");

    a_zero_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && zero_reg) |-> (sum_reg == '0))
        else $error("zero-sum flag with nonzero sum");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && e_reg == LAST_IDX) |=> (state_reg == S_IDLE))
        else $error("no return to idle after last transaction");

endmodule

// ===== bench/pomdp_belief_update_top_tb.sv =====
`timescale 1ns / 1ps

module pomdp_belief_update_top_tb;
    import pbu_pkg::*;

    localparam int NS           = NUM_STATES_DEF;
    localparam int NA           = NUM_ACTIONS_DEF;
    localparam int NO           = NUM_OBSERVATIONS_DEF;
    localparam int PROB_LSB     = 15;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES  = 1000;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [ST_W-1:0]   idx;
        logic [PROB_W-1:0] value;
        logic              zero_sum;
        logic              last;
    } belief_entry_t;

    class belief_scoreboard;
        logic [PROB_W-1:0] trans [NA][NS][NS];
        logic [PROB_W-1:0] obsv [NA][NS][NO];
        logic [PROB_W-1:0] belief [NS];
        logic [31:0]       unnorm [NS];
        belief_entry_t     pending [$];
        int                failures;

        function void note_item(logic [CMD_W-1:0] cmd, logic [S_TDATA_W-1:0] d);
            logic [ACT_W-1:0]  act;
            logic [ST_W-1:0]   src;
            logic [ST_W-1:0]   dst;
            logic [OBS_W-1:0]  ob;
            logic [PROB_W-1:0] p;
            bit [63:0]         acc;
            bit [63:0]         part;
            bit [63:0]         total;
            belief_entry_t     e;
            act = d[2:0];
            src = d[6:3];
            dst = d[10:7];
            ob  = d[14:11];
            p   = d[PROB_LSB +: PROB_W];
            case (cmd)
                CMD_WR_T: if (act < NA && src < NS && dst < NS) trans[act][src][dst] = p;
                CMD_WR_O: if (act < NA && dst < NS && ob < NO) obsv[act][dst][ob] = p;
                CMD_WR_B: if (src < NS) belief[src] = p;
                CMD_UPDATE: begin
                    if (act < NA && ob < NO) begin
                        total = 0;
                        for (int i = 0; i < NS; i++) begin
                            acc = 0;
                            for (int j = 0; j < NS; j++) begin
                                part = (64'(belief[j]) * 64'(trans[act][j][i])) >> FRAC;
                                acc += (part * 64'(obsv[act][i][ob])) >> FRAC;
                            end
                            unnorm[i] = acc[31:0];
                            total += acc;
                        end
                        // zero sum: belief kept and re-emitted with the flag
                        for (int i = 0; i < NS; i++) begin
                            e.idx      = ST_W'(i);
                            e.zero_sum = (total == 0);
                            e.last     = (i == NS - 1);
                            if (total == 0) begin
                                e.value = belief[i];
                            end else begin
                                e.value   = PROB_W'((64'(unnorm[i]) << FRAC) / total);
                                belief[i] = e.value;
                            end
                            pending = {pending, e};
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(belief_entry_t got);
            belief_entry_t want;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: idx %0d value %0d zero_sum %0b last %0b",
                             got.idx, got.value, got.zero_sum, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.idx !== want.idx || got.value !== want.value ||
                got.zero_sum !== want.zero_sum || got.last !== want.last) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("mismatch: expected idx %0d value %0d zero_sum %0b last %0b",
                             want.idx, want.value, want.zero_sum, want.last);
                    $display("          actual   idx %0d value %0d zero_sum %0b last %0b",
                             got.idx, got.value, got.zero_sum, got.last);
                end
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = CMD_WR_T;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int   snd_idle_pct = 28;
    int   rcv_idle_pct = 86;
    logic hold_req     = 1'b0;
    logic hold_rx      = 1'b0;
    int   quiet_cycles = 0;

    belief_scoreboard sb = new;

    pomdp_belief_update_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [S_TDATA_W-1:0] item_data(int unsigned act, int unsigned src,
                                                       int unsigned dst, int unsigned ob,
                                                       int unsigned p);
        item_data = {1'b0, p[PROB_W-1:0], ob[OBS_W-1:0], dst[ST_W-1:0], src[ST_W-1:0],
                     act[ACT_W-1:0]};
    endfunction

    // biased toward zero, one and values above one
    function automatic logic [PROB_W-1:0] rand_prob();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)       rand_prob = '0;
        else if (r < 16) rand_prob = 16'd32768;
        else if (r < 20) rand_prob = 16'hFFFF;
        else if (r < 25) rand_prob = PROB_W'($urandom_range(65535, 32769));
        else             rand_prob = PROB_W'($urandom_range(32768, 0));
    endfunction

    // leaves tvalid high after the transaction so back-to-back items need no toggle
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [S_TDATA_W-1:0] d);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        if (hold_rx) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial begin : rx_hold
        wait (hold_req);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(belief_entry_t'({m_tdata[3:0], m_tdata[19:4], m_tuser,
                                                 m_tlast}));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("pomdp_belief_update_top test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [S_TDATA_W-1:0] d;
        int unsigned          r;
        logic [PROB_W-1:0]    p;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every table entry is loaded before any update reads it
        for (int a = 0; a < NA; a++)
            for (int j = 0; j < NS; j++)
                for (int i = 0; i < NS; i++) begin
                    // action 3 is kept sparse so products often vanish
                    p = (a == 3 && $urandom_range(99) < 85) ? '0 : rand_prob();
                    send_item(CMD_WR_T, item_data(a, j, i, $urandom(), p));
                end
        for (int a = 0; a < NA; a++)
            for (int i = 0; i < NS; i++)
                for (int o = 0; o < NO; o++) begin
                    if (a == 0 && o == NO - 1) p = '0;          // forces a zero sum
                    else if (a == NA - 1 && o == 0) p = 16'hFFFF;
                    else p = rand_prob();
                    send_item(CMD_WR_O, item_data(a, $urandom(), i, o, p));
                end

        for (int i = 0; i < NS; i++) begin
            if (i == 0)           p = '0;
            else if (i == 1)      p = 16'd32768;
            else if (i == NS - 1) p = 16'hFFFF;
            else                  p = rand_prob();
            send_item(CMD_WR_B, item_data($urandom(), i, $urandom(), $urandom(), p));
        end
        send_item(CMD_UPDATE, item_data(0, 0, 0, 0, 0));
        send_item(CMD_UPDATE, item_data(NA - 1, NS - 1, NS - 1, 0, 16'hFFFF));
        send_item(CMD_UPDATE, item_data(0, 0, 0, NO - 1, 0));
        send_item(CMD_UPDATE, item_data(3, 5, 9, 7, 16'h5555));
        send_item(CMD_WR_T, item_data(NA - 1, NS - 1, NS - 1, NO - 1, 16'hFFFF));
        send_item(CMD_WR_O, item_data(NA - 1, NS - 1, NS - 1, NO - 1, 0));
        send_item(CMD_UPDATE, item_data(NA - 1, 0, 0, NO - 1, 16'hAAAA));

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 3) begin
                snd_idle_pct = 86;
                rcv_idle_pct = 28;
            end
            if (k == 2 * RANDOM_ITEMS / 3) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            if (k == 5 * RANDOM_ITEMS / 6)
                hold_req = 1'b1;
            r = $urandom_range(99);
            d = $urandom();
            d[S_TDATA_W-1] = 1'b0;
            if (r < 45) begin
                send_item(CMD_UPDATE, d);
            end else begin
                d[PROB_LSB +: PROB_W] = rand_prob();
                if (r < 65)      send_item(CMD_WR_B, d);
                else if (r < 85) send_item(CMD_WR_T, d);
                else             send_item(CMD_WR_O, d);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("pomdp_belief_update_top test passed");
        end else begin
            $display("pomdp_belief_update_top test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pbu_pkg.sv
sv/pbu_ram.sv
sv/pbu_cell.sv
sv/pbu_div.sv
sv/pomdp_belief_update_top.sv
bench/pomdp_belief_update_top_tb.sv
